// ===== rtl/ocs_pkg.sv =====
// ----------------------------------------------------------------------------
// ocs_pkg
// Types and constants shared by the cuff sequencer modules.
// ----------------------------------------------------------------------------
package ocs_pkg;

    localparam int SAMPLE_W = 12;
    localparam int PHASE_W  = 3;
    localparam int COUNT_W  = 4;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FAST    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_WATCH   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DEFLATE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

    localparam logic FUNC_START = 1'b0;

    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_LIMIT    = 3'd1;
    localparam logic [2:0] REG_STOP     = 3'd2;
    localparam logic [2:0] REG_FLOOR    = 3'd3;
    localparam logic [2:0] REG_AMP_THR  = 3'd4;
    localparam logic [2:0] REG_QUIET    = 3'd5;
    localparam logic [2:0] REG_INTERVAL = 3'd6;

    localparam logic [SAMPLE_W-1:0] RST_TARGET   = 12'd2035;
    localparam logic [SAMPLE_W-1:0] RST_LIMIT    = 12'd3822;
    localparam logic [SAMPLE_W-1:0] RST_STOP     = 12'd844;
    localparam logic [SAMPLE_W-1:0] RST_FLOOR    = 12'd398;
    localparam logic [SAMPLE_W-1:0] RST_AMP_THR  = 12'd298;
    localparam logic [COUNT_W-1:0]  RST_QUIET    = 4'd2;
    localparam logic [COUNT_W-1:0]  RST_INTERVAL = 4'd10;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 4'd15;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] pressure_code;
        logic [SAMPLE_W-1:0] band_code;
    } t_in_beat;

    typedef struct packed {
        logic                pump_on;
        logic                valve_closed;
        logic [PHASE_W-1:0]  phase;
        logic                oscillating;
        logic [SAMPLE_W-1:0] amplitude;
        logic                pulse_seen;
    } t_out_beat;

    typedef struct packed {
        logic store;
        logic rotate;
        logic first;
    } t_win_ctrl;

endpackage

// ===== rtl/oscillometric_cuff_sequencer.sv =====
// ----------------------------------------------------------------------------
// oscillometric_cuff_sequencer
// Pump and valve sequencer with a peak-to-peak oscillation check on a window.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_beat)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_beat)
//   cfg     | input     | APB write, pready high    | pwdata[11:0] or [3:0]
//
// An item without a window check reaches the output through the execution and finish states and the
// output register. An item with a check goes from execution through the scan state,
// which rotates the cell chain past the peak and trough tracker, and the check state.
// Reset is synchronous and active low; the window contents are not cleared.
// The input stalls while an item is in work; a stalled result beat holds.
// ----------------------------------------------------------------------------
module oscillometric_cuff_sequencer #(
    parameter int WINDOW_DEPTH = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ocs_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ocs_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ocs_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [SAMPLE_W-1:0] r_target, r_limit, r_stop, r_floor, r_amp_thr;
    logic [COUNT_W-1:0]  r_quiet_need, r_interval;

    logic [2:0]          r_state, n_state;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_full, n_full;
    logic [COUNT_W-1:0]  r_quiet, n_quiet;
    logic [COUNT_W-1:0]  r_ic, n_ic;
    logic                r_pulse, n_pulse;
    logic                r_verdict, n_verdict;
    logic [SAMPLE_W-1:0] r_amp, n_amp;
    logic [IDX_W-1:0]    r_scan, n_scan;
    t_in_beat            r_item;
    logic                r_out_valid;
    t_out_beat           r_out;

    t_win_ctrl           w_ctrl;
    logic [SAMPLE_W-1:0] w_hi, w_lo, w_diff;
    logic                w_in_acc, w_cfg_wr, w_load, w_full_after, w_osc, w_pulse_new;
    logic [COUNT_W-1:0]  w_ic_inc, w_quiet_new;
    logic                w_clear;

    ocs_window #(.DEPTH(WINDOW_DEPTH)) u_window (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_sample(r_item.band_code),
        .o_hi    (w_hi),
        .o_lo    (w_lo)
    );

    assign w_in_acc     = i_in_valid & ~o_in_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign w_cfg_wr     = psel & penable & pwrite;
    assign pready       = 1'b1;
    assign w_full_after = r_full | (r_idx == IDX_LAST);
    assign w_ic_inc     = (r_ic == COUNT_MAX) ? COUNT_MAX : r_ic + 4'd1;
    assign w_diff       = w_hi - w_lo;
    assign w_quiet_new  = (w_diff < r_amp_thr) ?
                          ((r_quiet == COUNT_MAX) ? COUNT_MAX : r_quiet + 4'd1) : '0;
    assign w_osc        = !(w_quiet_new >= r_quiet_need);
    assign w_pulse_new  = r_pulse | w_osc;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_full    = r_full;
        n_quiet   = r_quiet;
        n_ic      = r_ic;
        n_pulse   = r_pulse;
        n_verdict = r_verdict;
        n_amp     = r_amp;
        n_scan    = r_scan;
        w_ctrl    = '0;
        w_clear   = 1'b0;
        w_load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_item.func == FUNC_START) begin
                    w_clear = 1'b1;
                    n_phase = PH_FAST;
                end else begin
                    unique case (r_phase)
                        PH_FAST: begin
                            if (r_item.pressure_code > r_target) begin
                                n_phase = PH_WATCH;
                            end
                        end
                        PH_WATCH: begin
                            w_ctrl.store = 1'b1;
                            n_idx  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                            n_full = w_full_after;
                            if (w_full_after) begin
                                n_state = S_SCAN;
                            end else begin
                                n_verdict = 1'b1;
                                if (r_item.pressure_code > r_limit) begin
                                    w_clear = 1'b1;
                                    n_phase = PH_DEFLATE;
                                end
                            end
                        end
                        PH_DEFLATE: begin
                            w_ctrl.store = 1'b1;
                            n_idx  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
                            n_full = w_full_after;
                            if (w_ic_inc >= r_interval) begin
                                n_ic = '0;
                                if (w_full_after) begin
                                    n_state = S_SCAN;
                                end else begin
                                    n_verdict = 1'b1;
                                    n_pulse   = 1'b1;
                                    if (r_item.pressure_code < r_floor) begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            end else begin
                                n_ic = w_ic_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_ctrl.rotate = 1'b1;
                w_ctrl.first  = (r_scan == '0);
                if (r_scan == IDX_LAST) begin
                    n_scan  = '0;
                    n_state = S_CHECK;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_CHECK: begin
                n_state   = S_FIN;
                n_amp     = w_diff;
                n_quiet   = w_quiet_new;
                n_verdict = w_osc;
                if (r_phase == PH_WATCH) begin
                    if (!w_osc || r_item.pressure_code > r_limit) begin
                        w_clear = 1'b1;
                        n_phase = PH_DEFLATE;
                    end
                end else begin
                    n_pulse = w_pulse_new;
                    if ((r_item.pressure_code < r_stop && w_pulse_new && !w_osc) ||
                        r_item.pressure_code < r_floor) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_clear) begin
            n_idx     = '0;
            n_full    = 1'b0;
            n_quiet   = '0;
            n_ic      = '0;
            n_pulse   = 1'b0;
            n_verdict = 1'b1;
            n_amp     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_idx       <= '0;
            r_full      <= 1'b0;
            r_quiet     <= '0;
            r_ic        <= '0;
            r_pulse     <= 1'b0;
            r_verdict   <= 1'b1;
            r_amp       <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_full      <= n_full;
            r_quiet     <= n_quiet;
            r_ic        <= n_ic;
            r_pulse     <= n_pulse;
            r_verdict   <= n_verdict;
            r_amp       <= n_amp;
            r_scan      <= n_scan;
            r_out_valid <= w_load | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_data;
        end
        if (w_load) begin
            r_out.pump_on      <= (r_phase == PH_FAST) || (r_phase == PH_WATCH);
            r_out.valve_closed <= (r_phase == PH_FAST) || (r_phase == PH_WATCH);
            r_out.phase        <= r_phase;
            r_out.oscillating  <= r_verdict;
            r_out.amplitude    <= r_amp;
            r_out.pulse_seen   <= r_pulse;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= RST_TARGET;
            r_limit      <= RST_LIMIT;
            r_stop       <= RST_STOP;
            r_floor      <= RST_FLOOR;
            r_amp_thr    <= RST_AMP_THR;
            r_quiet_need <= RST_QUIET;
            r_interval   <= RST_INTERVAL;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_TARGET:   r_target     <= pwdata[SAMPLE_W-1:0];
                REG_LIMIT:    r_limit      <= pwdata[SAMPLE_W-1:0];
                REG_STOP:     r_stop       <= pwdata[SAMPLE_W-1:0];
                REG_FLOOR:    r_floor      <= pwdata[SAMPLE_W-1:0];
                REG_AMP_THR:  r_amp_thr    <= pwdata[SAMPLE_W-1:0];
                REG_QUIET:    r_quiet_need <= pwdata[COUNT_W-1:0];
                REG_INTERVAL: r_interval   <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_TARGET:   prdata = 32'(r_target);
            REG_LIMIT:    prdata = 32'(r_limit);
            REG_STOP:     prdata = 32'(r_stop);
            REG_FLOOR:    prdata = 32'(r_floor);
            REG_AMP_THR:  prdata = 32'(r_amp_thr);
            REG_QUIET:    prdata = 32'(r_quiet_need);
            REG_INTERVAL: prdata = 32'(r_interval);
            default:      prdata = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_scan_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_full)
        else $error("window scan started on a window that is not full");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || !i_out_stall)) |=> r_out_valid)
        else $error("finished item did not produce a result beat");

    a_drive_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pump_on ==
            (o_out_data.phase == PH_FAST || o_out_data.phase == PH_WATCH)))
        else $error("pump drive disagrees with reported phase");

endmodule

// ===== rtl/ocs_cell.sv =====
// ----------------------------------------------------------------------------
// ocs_cell
// One window cell: holds a sample and takes its neighbor's on each shift.
// ----------------------------------------------------------------------------
module ocs_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ocs_pkg::SAMPLE_W-1:0] i_d,
    output logic [ocs_pkg::SAMPLE_W-1:0] o_q
);
    import ocs_pkg::*;

    logic [SAMPLE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/ocs_window.sv =====
// ----------------------------------------------------------------------------
// ocs_window
// Chain of sample cells with a peak and trough tracker on the tail cell.
// ----------------------------------------------------------------------------
module ocs_window #(
    parameter int DEPTH = 50
) (
    input  logic                         i_clk,
    input  ocs_pkg::t_win_ctrl           i_ctrl,
    input  logic [ocs_pkg::SAMPLE_W-1:0] i_sample,
    output logic [ocs_pkg::SAMPLE_W-1:0] o_hi,
    output logic [ocs_pkg::SAMPLE_W-1:0] o_lo
);
    import ocs_pkg::*;

    logic [SAMPLE_W-1:0] w_q [DEPTH];
    logic [SAMPLE_W-1:0] w_head;
    logic [SAMPLE_W-1:0] w_tail;
    logic                w_en;
    logic [SAMPLE_W-1:0] r_hi;
    logic [SAMPLE_W-1:0] r_lo;

    assign w_tail = w_q[DEPTH-1];
    assign w_head = i_ctrl.store ? i_sample : w_tail;
    assign w_en   = i_ctrl.store | i_ctrl.rotate;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            ocs_cell u_cell (.i_clk(i_clk), .i_en(w_en), .i_d(w_head), .o_q(w_q[g]));
        end else begin : g_body
            ocs_cell u_cell (.i_clk(i_clk), .i_en(w_en), .i_d(w_q[g-1]), .o_q(w_q[g]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rotate) begin
            if (i_ctrl.first || w_tail > r_hi) begin
                r_hi <= w_tail;
            end
            if (i_ctrl.first || w_tail < r_lo) begin
                r_lo <= w_tail;
            end
        end
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule
